// File: sv/s2cdt_pkg.sv
// ----------------------------------------------------------------------------
// s2cdt_pkg
// Shared types, constants and elaboration-time table builders for the
// seconds-to-calendar converter.
// ----------------------------------------------------------------------------
package s2cdt_pkg;

   // Years covered by the year-start table (enough for a 32-bit second count)
   localparam int YEAR_TAB_DEPTH = 137;

   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

   // Reciprocals: x / d == (x * RECIP) >> SHIFT, exact over the used range
   localparam logic [25:0] DAY_RECIP  = 26'd50903317;   // (t >> 7) / 675
   localparam int          DAY_SHIFT  = 35;
   localparam logic [15:0] YEAR_RECIP = 16'd45840;      // days / 366
   localparam int          YEAR_SHIFT = 24;
   localparam logic [12:0] HOUR_RECIP = 13'd4661;       // (rem >> 4) / 225
   localparam int          HOUR_SHIFT = 20;
   localparam logic [10:0] MIN_RECIP  = 11'd1093;       // (rs >> 2) / 15
   localparam int          MIN_SHIFT  = 14;

   typedef logic [16:0] year_start_tab_type [0:YEAR_TAB_DEPTH-1];
   typedef logic [8:0]  month_start_type [0:11];

   localparam month_start_type MONTH_START_COMMON =
      '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};
   localparam month_start_type MONTH_START_LEAP =
      '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
        9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335};

   function automatic logic is_leap(input int year);
      return (((year % 4) == 0) && ((year % 100) != 0)) || ((year % 400) == 0);
   endfunction

   // Day offset of Jan 1 of each year relative to Jan 1 of the base year
   function automatic year_start_tab_type year_starts(input int base);
      year_start_tab_type tab;
      int acc;
      acc = 0;
      for (int i = 0; i < YEAR_TAB_DEPTH; i++) begin
         tab[i] = 17'(acc);
         acc = acc + (is_leap(base + i) ? 366 : 365);
      end
      return tab;
   endfunction

   function automatic logic [YEAR_TAB_DEPTH-1:0] leap_flags(input int base);
      logic [YEAR_TAB_DEPTH-1:0] flags;
      for (int i = 0; i < YEAR_TAB_DEPTH; i++) begin
         flags[i] = is_leap(base + i);
      end
      return flags;
   endfunction

endpackage

// File: sv/s2cdt_ifs.sv
// ----------------------------------------------------------------------------
// s2cdt channel interfaces
// Valid/ready channels for the timestamp request and the calendar response.
// ----------------------------------------------------------------------------
interface s2cdt_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] seconds_since_epoch;

   modport source (output valid, output seconds_since_epoch, input ready);
   modport sink   (input valid, input seconds_since_epoch, output ready);
endinterface

interface s2cdt_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  sec_of_minute;
   logic [5:0]  min_of_hour;
   logic [4:0]  hour_of_day;
   logic [4:0]  day_of_month;
   logic [3:0]  month_of_year;
   logic [11:0] calendar_year;

   modport source (output valid, output sec_of_minute, output min_of_hour,
                   output hour_of_day, output day_of_month, output month_of_year,
                   output calendar_year, input ready);
   modport sink   (input valid, input sec_of_minute, input min_of_hour,
                   input hour_of_day, input day_of_month, input month_of_year,
                   input calendar_year, output ready);
endinterface

// File: sv/seconds_to_calendar_datetime.sv
// ----------------------------------------------------------------------------
// seconds_to_calendar_datetime
// Converts a 32-bit epoch second count into Gregorian date and time of day.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ch carries one timestamp per transaction (seconds since Jan 1 of
//    BASE_YEAR, 00:00:00). rsp_ch returns second, minute, hour, day, month
//    and year for it, one response per request, in order.
//  - Six register stages; a request accepted on req_ch passes through
//    stages 1 to 6 in order and shows on rsp_ch from the stage 6 registers.
//  - Throughput is one transaction per cycle while rsp_ch does not stall; the depth is set by the chain
//    of reciprocal multiplies (day split, year estimate, hour, minute) with
//    a register after each.
//  - Reset (synchronous, active high) clears the stage valid bits only.
//  - When the receiver holds rsp_ch.ready low with a result waiting, the
//    whole pipe freezes and req_ch.ready drops; nothing is lost or repeated.
//    Empty stages still fill while the output slot is free.
// ----------------------------------------------------------------------------
module seconds_to_calendar_datetime #(
   parameter int BASE_YEAR = 1970
) (
   input  logic        clock,
   input  logic        reset,
   s2cdt_req_if.sink   req_ch,
   s2cdt_rsp_if.source rsp_ch
);

   localparam s2cdt_pkg::year_start_tab_type YEAR_START =
      s2cdt_pkg::year_starts(BASE_YEAR);
   localparam logic [s2cdt_pkg::YEAR_TAB_DEPTH-1:0] LEAP_YEAR =
      s2cdt_pkg::leap_flags(BASE_YEAR);
   localparam logic [11:0] BASE_YEAR_W = 12'(BASE_YEAR);

   // Global advance: the pipe moves whenever the output slot is free or taken
   logic       advance;
   logic [5:0] vld_ff;
   logic [5:0] vld_in;

   assign advance      = !vld_ff[5] || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign vld_in       = {vld_ff[4:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // ---- Stage 1: whole days = t / 86400 = (t >> 7) / 675 ----
   logic [50:0] day_prod;
   logic [31:0] s1_t_ff;
   logic [15:0] s1_days_ff;
   logic [15:0] s1_days_in;

   assign day_prod   = 51'(req_ch.seconds_since_epoch[31:7]) * 51'(s2cdt_pkg::DAY_RECIP);
   assign s1_days_in = day_prod[s2cdt_pkg::DAY_SHIFT +: 16];

   // ---- Stage 2: second of day, and year estimate days / 366 (low bound) ----
   logic [31:0] day_secs;
   logic [31:0] year_prod;
   logic [16:0] s2_rem_ff;
   logic [16:0] s2_rem_in;
   logic [15:0] s2_days_ff;
   logic [7:0]  s2_yest_ff;
   logic [7:0]  s2_yest_in;

   assign day_secs   = 32'(s1_days_ff) * 32'(s2cdt_pkg::SECS_PER_DAY);
   assign s2_rem_in  = 17'(s1_t_ff - day_secs);
   assign year_prod  = 32'(s1_days_ff) * 32'(s2cdt_pkg::YEAR_RECIP);
   assign s2_yest_in = year_prod[s2cdt_pkg::YEAR_SHIFT +: 8];

   // ---- Stage 3: true year is the estimate or one past it; hour of day ----
   logic [7:0]  yest_next;
   logic [16:0] start_next;
   logic        take_next;
   logic [7:0]  s3_yidx_in;
   logic [16:0] year_start;
   logic [8:0]  s3_doy_ff;
   logic [8:0]  s3_doy_in;
   logic        s3_leap_ff;
   logic [11:0] s3_year_ff;
   logic [16:0] s3_rem_ff;
   logic [24:0] hour_prod;
   logic [4:0]  s3_hour_ff;
   logic [4:0]  s3_hour_in;

   assign yest_next  = s2_yest_ff + 8'd1;
   assign start_next = YEAR_START[yest_next];
   assign take_next  = (17'(s2_days_ff) >= start_next);
   assign s3_yidx_in = take_next ? yest_next : s2_yest_ff;
   assign year_start = take_next ? start_next : YEAR_START[s2_yest_ff];
   assign s3_doy_in  = 9'(17'(s2_days_ff) - year_start);
   assign hour_prod  = 25'(s2_rem_ff[16:4]) * 25'(s2cdt_pkg::HOUR_RECIP);
   assign s3_hour_in = hour_prod[s2cdt_pkg::HOUR_SHIFT +: 5];

   // ---- Stage 4: month index by parallel compares; seconds within hour ----
   logic [3:0]  s4_mon_ff;
   logic [3:0]  s4_mon_in;
   logic [8:0]  s4_doy_ff;
   logic        s4_leap_ff;
   logic [11:0] s4_year_ff;
   logic [4:0]  s4_hour_ff;
   logic [11:0] s4_rs_ff;
   logic [11:0] s4_rs_in;
   logic [16:0] hour_secs;

   always_comb begin
      s4_mon_in = '0;
      for (int m = 1; m < 12; m++) begin
         if (s3_doy_ff >= (s3_leap_ff ? s2cdt_pkg::MONTH_START_LEAP[m]
                                      : s2cdt_pkg::MONTH_START_COMMON[m])) begin
            s4_mon_in = s4_mon_in + 4'd1;
         end
      end
   end

   assign hour_secs = 17'(s3_hour_ff) * 17'(s2cdt_pkg::SECS_PER_HOUR);
   assign s4_rs_in  = 12'(s3_rem_ff - hour_secs);

   // ---- Stage 5: day of month; minute = (rs >> 2) / 15 ----
   logic [8:0]  month_start;
   logic [4:0]  s5_day_ff;
   logic [4:0]  s5_day_in;
   logic [3:0]  s5_mon_ff;
   logic [11:0] s5_year_ff;
   logic [4:0]  s5_hour_ff;
   logic [11:0] s5_rs_ff;
   logic [20:0] min_prod;
   logic [5:0]  s5_min_ff;
   logic [5:0]  s5_min_in;

   assign month_start = s4_leap_ff ? s2cdt_pkg::MONTH_START_LEAP[s4_mon_ff]
                                   : s2cdt_pkg::MONTH_START_COMMON[s4_mon_ff];
   assign s5_day_in   = 5'(s4_doy_ff - month_start + 9'd1);
   assign min_prod    = 21'(s4_rs_ff[11:2]) * 21'(s2cdt_pkg::MIN_RECIP);
   assign s5_min_in   = min_prod[s2cdt_pkg::MIN_SHIFT +: 6];

   // ---- Stage 6: output register, second of minute ----
   logic [11:0] min_secs;
   logic [5:0]  s6_sec_ff;
   logic [5:0]  s6_sec_in;
   logic [5:0]  s6_min_ff;
   logic [4:0]  s6_hour_ff;
   logic [4:0]  s6_day_ff;
   logic [3:0]  s6_mon_ff;
   logic [11:0] s6_year_ff;

   assign min_secs  = 12'(s5_min_ff) * 12'(s2cdt_pkg::SECS_PER_MIN);
   assign s6_sec_in = 6'(s5_rs_ff - min_secs);

   // Payload registers: no reset, loaded whenever the pipe advances
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_t_ff    <= req_ch.seconds_since_epoch;
         s1_days_ff <= s1_days_in;

         s2_rem_ff  <= s2_rem_in;
         s2_days_ff <= s1_days_ff;
         s2_yest_ff <= s2_yest_in;

         s3_doy_ff  <= s3_doy_in;
         s3_leap_ff <= LEAP_YEAR[s3_yidx_in];
         s3_year_ff <= BASE_YEAR_W + 12'(s3_yidx_in);
         s3_rem_ff  <= s2_rem_ff;
         s3_hour_ff <= s3_hour_in;

         s4_mon_ff  <= s4_mon_in;
         s4_doy_ff  <= s3_doy_ff;
         s4_leap_ff <= s3_leap_ff;
         s4_year_ff <= s3_year_ff;
         s4_hour_ff <= s3_hour_ff;
         s4_rs_ff   <= s4_rs_in;

         s5_day_ff  <= s5_day_in;
         s5_mon_ff  <= s4_mon_ff + 4'd1;
         s5_year_ff <= s4_year_ff;
         s5_hour_ff <= s4_hour_ff;
         s5_rs_ff   <= s4_rs_ff;
         s5_min_ff  <= s5_min_in;

         s6_sec_ff  <= s6_sec_in;
         s6_min_ff  <= s5_min_ff;
         s6_hour_ff <= s5_hour_ff;
         s6_day_ff  <= s5_day_ff;
         s6_mon_ff  <= s5_mon_ff;
         s6_year_ff <= s5_year_ff;
      end
   end

   assign rsp_ch.valid         = vld_ff[5];
   assign rsp_ch.sec_of_minute = s6_sec_ff;
   assign rsp_ch.min_of_hour   = s6_min_ff;
   assign rsp_ch.hour_of_day   = s6_hour_ff;
   assign rsp_ch.day_of_month  = s6_day_ff;
   assign rsp_ch.month_of_year = s6_mon_ff;
   assign rsp_ch.calendar_year = s6_year_ff;

endmodule

// File: sv/s2cdt_checker.sv
// ----------------------------------------------------------------------------
// s2cdt_checker
// Port-level assertions for the seconds-to-calendar converter.
// ----------------------------------------------------------------------------
module s2cdt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  sec_of_minute,
   input logic [5:0]  min_of_hour,
   input logic [4:0]  hour_of_day,
   input logic [4:0]  day_of_month,
   input logic [3:0]  month_of_year,
   input logic [11:0] calendar_year
);

   // Stalled response holds its transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(sec_of_minute)
         && $stable(min_of_hour) && $stable(hour_of_day) && $stable(day_of_month)
         && $stable(month_of_year) && $stable(calendar_year))
      else $error("stalled response changed");

   // Pipe only pushes back when the output slot is full and not taken
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("request stalled with free output slot");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> sec_of_minute < 6'd60 && min_of_hour < 6'd60 && hour_of_day < 5'd24
         && day_of_month != 5'd0 && month_of_year != 4'd0 && month_of_year <= 4'd12)
      else $error("time field out of range");

   // Short months never overflow
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (month_of_year == 4'd2) |-> day_of_month <= 5'd29)
      else $error("February day out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (month_of_year == 4'd4 || month_of_year == 4'd6
         || month_of_year == 4'd9 || month_of_year == 4'd11) |-> day_of_month <= 5'd30)
      else $error("30-day month overflow");

endmodule

bind seconds_to_calendar_datetime s2cdt_checker u_s2cdt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .sec_of_minute (rsp_ch.sec_of_minute),
   .min_of_hour   (rsp_ch.min_of_hour),
   .hour_of_day   (rsp_ch.hour_of_day),
   .day_of_month  (rsp_ch.day_of_month),
   .month_of_year (rsp_ch.month_of_year),
   .calendar_year (rsp_ch.calendar_year)
);

// File: sim/seconds_to_calendar_datetime_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seconds_to_calendar_datetime_tb
// Self-checking bench for the epoch-seconds to calendar converter. Directed
// corners (time-of-day limits, month and year starts, leap days, the top of
// the 32-bit range) are followed by random timestamps, many of them on month
// boundaries. A local calendar model predicts every response; the monitor
// checks each response field by field, in order, under random back-pressure.
// ----------------------------------------------------------------------------
module seconds_to_calendar_datetime_tb;

   localparam int BASE_YEAR     = 1970;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 1400;
   localparam int IDLE_PCT      = 18;
   localparam int LONG_STALL    = 120;   // receiver hold-off length, cycles
   localparam int STALL_AT_RX   = 400;   // responses seen before the hold-off
   localparam int QUIET_LO      = 600;   // no idling on either side in here
   localparam int QUIET_HI      = 850;
   localparam int TAIL_CYCLES   = 20;    // drain time after the last due response is back

   typedef struct packed {
      logic [5:0]  sec_of_minute;
      logic [5:0]  min_of_hour;
      logic [4:0]  hour_of_day;
      logic [4:0]  day_of_month;
      logic [3:0]  month_of_year;
      logic [11:0] calendar_year;
   } calendar_type;

   // A pending timestamp; drain_first makes the sender wait until every
   // outstanding response is back before offering it.
   typedef struct packed {
      logic [31:0] secs;
      logic        drain_first;
   } stamp_type;

   logic clock;
   logic reset;

   s2cdt_req_if req_if ();
   s2cdt_rsp_if rsp_if ();

   seconds_to_calendar_datetime #(
      .BASE_YEAR (BASE_YEAR)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source)
   );

   stamp_type    timestamp_queue [$];
   calendar_type calendar_due    [$];
   logic [31:0]  secs_due        [$];   // input behind each due entry, for reports

   int unsigned cycle_count = 0;
   int unsigned tx_count    = 0;   // accepted requests
   int unsigned rx_count    = 0;   // accepted responses
   int unsigned mismatches  = 0;
   bit          req_took    = 1'b0;

   // receiver hold-off bookkeeping
   int unsigned stall_left  = 0;
   bit          stall_done  = 1'b0;

   // -------------------------------------------------------------------------
   // Calendar helpers
   // -------------------------------------------------------------------------
   function automatic bit year_is_leap(input int unsigned yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
   endfunction

   // mon is zero based
   function automatic int unsigned days_in_month(input int unsigned mon, input bit lp);
      case (mon)
         1:          return lp ? 29 : 28;
         3, 5, 8, 10: return 30;
         default:    return 31;
      endcase
   endfunction

   // Expected response for one timestamp: peel whole years off the day count,
   // then whole months; what is left is the day within the month.
   function automatic calendar_type predict_calendar(input logic [31:0] secs);
      calendar_type cal;
      int unsigned  days;
      int unsigned  rem;
      int unsigned  yr;
      int unsigned  mon;
      int unsigned  ylen;
      bit           lp;
      days = secs / 86400;
      rem  = secs % 86400;
      yr   = BASE_YEAR;
      mon  = 0;
      ylen = year_is_leap(yr) ? 366 : 365;
      // >= here: a remainder equal to the year length is Jan 1 of the next year
      while (days >= ylen) begin
         days = days - ylen;
         yr   = yr + 1;
         ylen = year_is_leap(yr) ? 366 : 365;
      end
      lp = year_is_leap(yr);
      while (mon < 11 && days >= days_in_month(mon, lp)) begin
         days = days - days_in_month(mon, lp);
         mon  = mon + 1;
      end
      cal.sec_of_minute = 6'(rem % 60);
      cal.min_of_hour   = 6'((rem / 60) % 60);
      cal.hour_of_day   = 5'(rem / 3600);
      cal.day_of_month  = 5'(days + 1);
      cal.month_of_year = 4'(mon + 1);
      cal.calendar_year = 12'(yr);
      return cal;
   endfunction

   task automatic add_stamp(input logic [31:0] secs, input logic drain);
      stamp_type st;
      st.secs        = secs;
      st.drain_first = drain;
      timestamp_queue.push_back(st);
   endtask

   task automatic check_field(input string name, input logic [11:0] want,
                              input logic [11:0] got, input logic [31:0] secs);
      if (got !== want) begin
         $display("%0t: %s mismatch for t=%0d: expected %0d, actual %0d",
                  $time, name, secs, want, got);
         mismatches++;
      end
   endtask

   // -------------------------------------------------------------------------
   // Clock, reset, known values on every input from time zero
   // -------------------------------------------------------------------------
   initial begin
      clock                      = 1'b0;
      reset                      = 1'b1;
      req_if.valid               = 1'b0;
      req_if.seconds_since_epoch = '0;
      rsp_if.ready               = 1'b0;
   end

   always #5 clock = ~clock;

   // -------------------------------------------------------------------------
   // Rising edge: note accepted transactions on both channels, score
   // responses against the oldest prediction, and watch the cycle budget.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      calendar_type want;
      logic [31:0]  want_secs;
      cycle_count++;
      req_took = 1'b0;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            calendar_due.push_back(predict_calendar(req_if.seconds_since_epoch));
            secs_due.push_back(req_if.seconds_since_epoch);
            req_took = 1'b1;
            tx_count++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            rx_count++;
            if (calendar_due.size() == 0) begin
               $display({"%0t: response with no request waiting: expected none, ",
                         "actual %0d-%0d-%0d %0d:%0d:%0d"},
                        $time, rsp_if.calendar_year, rsp_if.month_of_year,
                        rsp_if.day_of_month, rsp_if.hour_of_day,
                        rsp_if.min_of_hour, rsp_if.sec_of_minute);
               mismatches++;
            end else begin
               want      = calendar_due.pop_front();
               want_secs = secs_due.pop_front();
               check_field("sec_of_minute", 12'(want.sec_of_minute),
                           12'(rsp_if.sec_of_minute), want_secs);
               check_field("min_of_hour", 12'(want.min_of_hour),
                           12'(rsp_if.min_of_hour), want_secs);
               check_field("hour_of_day", 12'(want.hour_of_day),
                           12'(rsp_if.hour_of_day), want_secs);
               check_field("day_of_month", 12'(want.day_of_month),
                           12'(rsp_if.day_of_month), want_secs);
               check_field("month_of_year", 12'(want.month_of_year),
                           12'(rsp_if.month_of_year), want_secs);
               check_field("calendar_year", want.calendar_year,
                           rsp_if.calendar_year, want_secs);
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding",
                  $time, calendar_due.size());
         $display("seconds_to_calendar_datetime regression: fail");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Request driver (falling edge). A new timestamp goes out only when the
   // channel is empty or the last one was taken at the previous rising edge.
   // Random idle slots, except inside the quiet window; a drain marker holds
   // the channel low until every response is back.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      bit quiet;
      quiet = (tx_count >= QUIET_LO) && (tx_count < QUIET_HI);
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_took) begin
         if (timestamp_queue.size() == 0) begin
            req_if.valid <= 1'b0;
         end else if (timestamp_queue[0].drain_first && calendar_due.size() != 0) begin
            req_if.valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
         end else begin
            req_if.valid               <= 1'b1;
            req_if.seconds_since_epoch <= timestamp_queue[0].secs;
            void'(timestamp_queue.pop_front());
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response receiver (falling edge). One long hold-off, counted here, lets
   // the pipe fill and back-pressure the request side; otherwise random
   // stalls outside the quiet window.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left   <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (!stall_done && rx_count >= STALL_AT_RX) begin
         stall_left   <= LONG_STALL;
         stall_done   <= 1'b1;
         rsp_if.ready <= 1'b0;
      end else if (rx_count >= QUIET_LO && rx_count < QUIET_HI) begin
         rsp_if.ready <= 1'b1;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin
      logic [31:0] corners [$];
      longint      secs64;
      int unsigned yr;
      int unsigned mon;
      int unsigned day;
      int unsigned pick;

      // Directed corners: time-of-day limits, first and last seconds of
      // months and years, leap days in 1972 and 2000, the non-leap century
      // 2100, Jan 1 2106, and bit patterns up to the 32-bit maximum.
      corners = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
                  32'd86400,
                  32'd31 * 86400 - 1, 32'd31 * 86400,          // Jan 31 / Feb 1 1970
                  32'd365 * 86400 - 1, 32'd365 * 86400,        // 1970 / 1971
                  32'd789 * 86400, 32'd790 * 86400 - 1,        // 1972-02-29 both ends
                  32'd790 * 86400, 32'd1096 * 86400,           // 1972-03-01, 1973-01-01
                  32'd951782400, 32'd951868800,                // 2000-02-29, 2000-03-01
                  32'd4107542399, 32'd4107542400,              // 2100-02-28 end, 03-01
                  32'd4291747200,                              // 2106-01-01
                  32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA,
                  32'h5555_5555, 32'hFFFF_FFFF};
      foreach (corners[i])
         add_stamp(corners[i], 1'b0);

      // Random part. The first random item and one in the middle wait for
      // the pipe to drain completely.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            secs64 = $urandom;
         end else if (pick < 65) begin
            // edges of a random day
            day    = $urandom_range(0, 49709);
            secs64 = longint'(day) * 86400 +
                     ($urandom_range(0, 1) ? 86399 - $urandom_range(0, 3)
                                           : $urandom_range(0, 3));
         end else begin
            // first second of a random month, or the second on either side of it
            yr  = $urandom_range(BASE_YEAR, 2106);
            mon = $urandom_range(0, 11);
            day = 0;
            for (int y = BASE_YEAR; y < yr; y++)
               day += year_is_leap(y) ? 366 : 365;
            for (int m = 0; m < mon; m++)
               day += days_in_month(m, year_is_leap(yr));
            secs64 = longint'(day) * 86400 + $urandom_range(0, 2) - 1;
            if (secs64 < 0 || secs64 > 64'hFFFF_FFFF)
               secs64 = 32'hFFFF_FFFF - $urandom_range(0, 3000000);
         end
         add_stamp(secs64[31:0], (n == 0) || (n == RANDOM_ITEMS / 2));
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (timestamp_queue.size() != 0 || req_if.valid)
         @(posedge clock);
      while (calendar_due.size() != 0)
         @(posedge clock);
      // then keep the clock running to catch any stray response
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && calendar_due.size() == 0) begin
         $display("seconds_to_calendar_datetime regression: pass");
      end else begin
         $display("seconds_to_calendar_datetime regression: fail");
      end
      $finish;
   end

endmodule

// File: files.f
sv/s2cdt_pkg.sv
sv/s2cdt_ifs.sv
sv/seconds_to_calendar_datetime.sv
sv/s2cdt_checker.sv
sim/seconds_to_calendar_datetime_tb.sv
